/* src/lps_pkg.sv */
// lps_pkg: shared types and constants for the logical path segment parser
// no dependencies; imported by every module of the block

package lps_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned CNT_W  = 2;
  localparam int unsigned STAT_W = 2;

  // segment type bytes
  localparam logic [BYTE_W-1:0] SEG_CLASS8  = 8'h20;
  localparam logic [BYTE_W-1:0] SEG_CLASS16 = 8'h21;
  localparam logic [BYTE_W-1:0] SEG_INST8   = 8'h24;
  localparam logic [BYTE_W-1:0] SEG_INST16  = 8'h25;
  localparam logic [BYTE_W-1:0] SEG_ATTR8   = 8'h30;
  localparam logic [BYTE_W-1:0] SEG_ATTR16  = 8'h31;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd1;
  localparam logic [STAT_W-1:0] ST_TRUNC   = 2'd2;

  localparam logic [CNT_W-1:0] CNT_NONE  = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONE   = 2'd1;
  localparam logic [CNT_W-1:0] CNT_TWO   = 2'd2;
  localparam logic [CNT_W-1:0] CNT_THREE = 2'd3;

  typedef enum logic [2:0] {
    PH_TYPE = 3'd0,
    PH_ID8  = 3'd1,
    PH_PAD  = 3'd2,
    PH_LO   = 3'd3,
    PH_HI   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    TGT_CLASS = 2'd0,
    TGT_INST  = 2'd1,
    TGT_ATTR  = 2'd2
  } target_t;

  typedef struct packed {
    logic [BYTE_W-1:0] path_byte;
    logic              is_final;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0]   class_id;
    logic [ID_W-1:0]   instance_id;
    logic [ID_W-1:0]   attribute_id;
    logic [CNT_W-1:0]  segment_count;
    logic [STAT_W-1:0] status;
  } result_t;

  // number of leading nonzero ids, class first
  function automatic logic [CNT_W-1:0] lead_count(
    input logic [ID_W-1:0] c,
    input logic [ID_W-1:0] i,
    input logic [ID_W-1:0] a
  );
    logic [CNT_W-1:0] n;
    n = CNT_NONE;
    if (c != '0) begin
      n = CNT_ONE;
      if (i != '0) begin
        n = CNT_TWO;
        if (a != '0) begin
          n = CNT_THREE;
        end
      end
    end
    return n;
  endfunction

endpackage

/* src/lps_if.sv */
// lps_in_if and lps_out_if: valid/ready channels of the path parser
// depends on lps_pkg for field widths

interface lps_in_if;
  import lps_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] path_byte;
  logic              is_final;

  modport source (output valid, path_byte, is_final, input ready);
  modport sink   (input valid, path_byte, is_final, output ready);
  modport mon    (input valid, ready, path_byte, is_final);
endinterface

interface lps_out_if;
  import lps_pkg::*;
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   class_id;
  logic [ID_W-1:0]   instance_id;
  logic [ID_W-1:0]   attribute_id;
  logic [CNT_W-1:0]  segment_count;
  logic [STAT_W-1:0] status;

  modport source (output valid, class_id, instance_id, attribute_id, segment_count, status,
                  input ready);
  modport sink   (input valid, class_id, instance_id, attribute_id, segment_count, status,
                  output ready);
  modport mon    (input valid, ready, class_id, instance_id, attribute_id, segment_count,
                  status);
endinterface

/* src/lps_in_stage.sv */
// lps_in_stage: input word register of the path parser
// depends on lps_pkg and lps_in_if

module lps_in_stage
  import lps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lps_in_if.sink    in_ch,
  input  logic      out_free,
  output logic      take,
  output in_word_t  word
);

  logic     vld_r;
  logic     vld_nxt;
  in_word_t word_r;

  // a final word may only move on when the result register can take it
  assign take        = vld_r && (!word_r.is_final || out_free);
  assign in_ch.ready = !vld_r || take;
  assign vld_nxt     = in_ch.valid || (vld_r && !take);
  assign word        = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      word_r.path_byte <= in_ch.path_byte;
      word_r.is_final  <= in_ch.is_final;
    end
  end

endmodule

/* src/lps_parse_core.sv */
// lps_parse_core: segment state machine and id registers
// depends on lps_pkg

module lps_parse_core
  import lps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     take,
  input  in_word_t word,
  output result_t  res
);

  phase_t            phase_r, phase_nxt;
  target_t           tgt_r, tgt_nxt;
  logic [ID_W-1:0]   class_r, class_nxt;
  logic [ID_W-1:0]   inst_r, inst_nxt;
  logic [ID_W-1:0]   attr_r, attr_nxt;
  logic [BYTE_W-1:0] low_r, low_nxt;
  logic              err_r, err_nxt;
  logic [ID_W-1:0]   id_val;
  logic              id_wr;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    tgt_nxt   = tgt_r;
    low_nxt   = low_r;
    err_nxt   = err_r;
    id_val    = {{(ID_W-BYTE_W){1'b0}}, word.path_byte};
    id_wr     = 1'b0;
    if (!err_r) begin
      case (phase_r)
        PH_ID8: begin
          id_wr     = 1'b1;
          phase_nxt = PH_TYPE;
        end
        PH_PAD: begin
          phase_nxt = PH_LO;
        end
        PH_LO: begin
          low_nxt   = word.path_byte;
          phase_nxt = PH_HI;
        end
        PH_HI: begin
          id_val    = {word.path_byte, low_r};
          id_wr     = 1'b1;
          phase_nxt = PH_TYPE;
        end
        default: begin
          case (word.path_byte)
            SEG_CLASS8: begin
              tgt_nxt   = TGT_CLASS;
              phase_nxt = PH_ID8;
            end
            SEG_INST8: begin
              tgt_nxt   = TGT_INST;
              phase_nxt = PH_ID8;
            end
            SEG_ATTR8: begin
              tgt_nxt   = TGT_ATTR;
              phase_nxt = PH_ID8;
            end
            SEG_CLASS16: begin
              tgt_nxt   = TGT_CLASS;
              phase_nxt = PH_PAD;
            end
            SEG_INST16: begin
              tgt_nxt   = TGT_INST;
              phase_nxt = PH_PAD;
            end
            SEG_ATTR16: begin
              tgt_nxt   = TGT_ATTR;
              phase_nxt = PH_PAD;
            end
            default: begin
              err_nxt   = 1'b1;
              phase_nxt = PH_TYPE;
            end
          endcase
        end
      endcase
    end
  end

  always_comb begin
    class_nxt = class_r;
    inst_nxt  = inst_r;
    attr_nxt  = attr_r;
    if (id_wr) begin
      case (tgt_r)
        TGT_CLASS: class_nxt = id_val;
        TGT_INST:  inst_nxt  = id_val;
        TGT_ATTR:  attr_nxt  = id_val;
        default:   ;
      endcase
    end
  end

  // result word, taken only when the current byte is final
  always_comb begin
    res = '0;
    if (err_nxt) begin
      res.status = ST_UNKNOWN;
    end else if (phase_nxt != PH_TYPE) begin
      res.status = ST_TRUNC;
    end else begin
      res.status        = ST_OK;
      res.class_id      = class_nxt;
      res.instance_id   = inst_nxt;
      res.attribute_id  = attr_nxt;
      res.segment_count = lead_count(class_nxt, inst_nxt, attr_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && word.is_final)) begin
      phase_r <= PH_TYPE;
      tgt_r   <= TGT_CLASS;
      class_r <= '0;
      inst_r  <= '0;
      attr_r  <= '0;
      low_r   <= '0;
      err_r   <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      tgt_r   <= tgt_nxt;
      class_r <= class_nxt;
      inst_r  <= inst_nxt;
      attr_r  <= attr_nxt;
      low_r   <= low_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

/* src/lps_out_stage.sv */
// lps_out_stage: result register driving the output channel
// depends on lps_pkg and lps_out_if

module lps_out_stage
  import lps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  result_t    res,
  output logic       out_free,
  lps_out_if.source  out_ch
);

  logic    vld_r;
  logic    vld_nxt;
  result_t res_r;

  assign out_free = !vld_r || out_ch.ready;
  assign vld_nxt  = load || (vld_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = vld_r;
  assign out_ch.class_id      = res_r.class_id;
  assign out_ch.instance_id   = res_r.instance_id;
  assign out_ch.attribute_id  = res_r.attribute_id;
  assign out_ch.segment_count = res_r.segment_count;
  assign out_ch.status        = res_r.status;

endmodule

/* src/logical_path_segment_parser.sv */
// Padded logical path parser: takes one path byte per cycle on in_ch and, on the
// byte marked final, returns class, instance and attribute ids, the count of
// leading nonzero ids and a status (ok, unknown segment type, truncated) on
// out_ch; after an error the ids and count are zero. A new byte is accepted
// every cycle; a final byte stalls the input only while the result register
// still holds an untaken word. The result passes from the input word register
// to the result register; the parse core updates its state once for each
// byte taken. After each result the parser returns to its reset state by itself.
// Depends on lps_pkg, lps_if, lps_in_stage, lps_parse_core, lps_out_stage.

module logical_path_segment_parser
  import lps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lps_in_if.sink    in_ch,
  lps_out_if.source out_ch
);

  logic     take;
  logic     out_free;
  in_word_t word;
  result_t  res;

  lps_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_free (out_free),
    .take     (take),
    .word     (word)
  );

  lps_parse_core u_parse_core (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .word  (word),
    .res   (res)
  );

  lps_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take && word.is_final),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

/* src/lps_checker.sv */
// lps_checker: port-level assertions for the path parser, bound to the top level
// depends on lps_pkg, lps_if and logical_path_segment_parser

module lps_checker
  import lps_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ID_W-1:0]   class_id,
  input logic [ID_W-1:0]   instance_id,
  input logic [ID_W-1:0]   attribute_id,
  input logic [CNT_W-1:0]  segment_count,
  input logic [STAT_W-1:0] status
);

  logic [CNT_W-1:0] exp_cnt;

  assign exp_cnt = lead_count(class_id, instance_id, attribute_id);

  // a result word stays offered until taken
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // error results carry no ids
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_OK) |->
      (class_id == '0) && (instance_id == '0) &&
      (attribute_id == '0) && (segment_count == CNT_NONE))
    else $error("nonzero ids on error result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == ST_OK) || (status == ST_UNKNOWN) ||
                  (status == ST_TRUNC))
    else $error("reserved status code");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (segment_count == exp_cnt))
    else $error("segment count does not match ids");

  // no result right after reset, and the input is open
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result word or stalled input right after reset");

endmodule

bind logical_path_segment_parser lps_checker u_lps_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .class_id      (out_ch.class_id),
  .instance_id   (out_ch.instance_id),
  .attribute_id  (out_ch.attribute_id),
  .segment_count (out_ch.segment_count),
  .status        (out_ch.status)
);
